/* src/wsd_pkg.sv */
// ============================================================================
// WebSocket deframer package
// Phase codes, result kinds, opcodes and the structs shared by the parser
// step logic and the top level.
// ============================================================================
package wsd_pkg;

    // Parser phase within one frame.
    typedef enum logic [2:0] {
        PH_HDR0    = 3'd0,
        PH_HDR1    = 3'd1,
        PH_LEN16   = 3'd2,
        PH_LEN64   = 3'd3,
        PH_MASK    = 3'd4,
        PH_PAYLOAD = 3'd5
    } phase_e;

    // Kind of one result word.
    typedef enum logic [2:0] {
        KIND_DATA       = 3'd0,
        KIND_PING       = 3'd1,
        KIND_EMPTY_DATA = 3'd2,
        KIND_EMPTY_PING = 3'd3,
        KIND_CLOSE      = 3'd4,
        KIND_LEN_ERR    = 3'd5,
        KIND_SEQ_ERR    = 3'd6,
        KIND_UNKNOWN    = 3'd7
    } kind_e;

    // Register indexes of the configuration port.
    localparam int REG_MAX_FRAME   = 0;
    localparam int REG_MAX_MESSAGE = 1;

    // Frame opcodes.
    localparam logic [3:0] OP_CONT   = 4'h0;
    localparam logic [3:0] OP_TEXT   = 4'h1;
    localparam logic [3:0] OP_BINARY = 4'h2;
    localparam logic [3:0] OP_CLOSE  = 4'h8;
    localparam logic [3:0] OP_PING   = 4'h9;
    localparam logic [3:0] OP_PONG   = 4'hA;

    // Seven-bit length codes that select an extended length field.
    localparam logic [6:0] LEN_CODE16 = 7'd126;
    localparam logic [6:0] LEN_CODE64 = 7'd127;

    // Byte counts of the extended length fields and of the masking key.
    localparam logic [3:0] LEN16_BYTES = 4'd2;
    localparam logic [3:0] LEN64_BYTES = 4'd8;
    localparam logic [3:0] KEY_BYTES   = 4'd4;

    // Reset value of both length limits.
    localparam logic [24:0] LIMIT_RESET = 25'd16777216;

    // Parser state of fixed width.
    typedef struct packed {
        phase_e      phase;
        logic [3:0]  field_byte_count;
        logic        fin_flag;
        logic [3:0]  current_opcode;
        logic        mask_present;
        logic [63:0] length_shift;
        logic [31:0] mask_key;
        logic [1:0]  payload_index;
        logic        message_open;
        logic        halted;
    } ctrl_t;

    // One result word.
    typedef struct packed {
        kind_e      kind;
        logic [7:0] data;
        logic [3:0] opcode;
        logic       frame_last;
        logic       message_last;
    } result_t;

endpackage

/* src/wsd_step.sv */
// ============================================================================
// WebSocket deframer step logic
// Computes the next parser state and the optional result word for one
// received byte. Purely combinational; the caller holds the state registers.
// ============================================================================
module wsd_step
    import wsd_pkg::*;
#(
    parameter int LEN_BITS = 25
)
(
    input  ctrl_t                cur,
    input  logic [LEN_BITS-1:0]  remaining,
    input  logic [LEN_BITS-1:0]  total,
    input  logic [7:0]           rx_byte,
    input  logic [63:0]          frame_lim,
    input  logic [LEN_BITS-1:0]  msg_lim,
    output ctrl_t                nxt,
    output logic [LEN_BITS-1:0]  remaining_next,
    output logic [LEN_BITS-1:0]  total_next,
    output logic                 res_valid,
    output result_t              res
);

    logic [63:0]         len_new;
    logic                len_zero;
    logic [LEN_BITS-1:0] len_low;
    logic                frame_bad;
    logic [LEN_BITS:0]   msg_sum;
    logic                msg_bad;
    logic                is_data;
    logic [3:0]          count_inc;
    logic                field_done;
    logic                mask_new;
    logic [LEN_BITS-1:0] rem_dec;
    logic                pay_last;
    logic [7:0]          key_byte;
    logic [7:0]          pay_byte;

    // Header completion outcome.
    logic                hd_valid;
    kind_e               hd_kind;
    logic                hd_flast;
    logic                hd_mlast;
    logic                hd_halt;
    logic                hd_open;
    logic [LEN_BITS-1:0] hd_total;

    // Length value after this byte, and the limit checks on it.
    always_comb
    begin
        case (cur.phase)
            PH_HDR1:
            begin
                len_new = {57'd0, rx_byte[6:0]};
            end
            PH_LEN16, PH_LEN64:
            begin
                len_new = {cur.length_shift[55:0], rx_byte};
            end
            default:
            begin
                len_new = cur.length_shift;
            end
        endcase
        len_zero  = (len_new == 64'd0);
        len_low   = len_new[LEN_BITS-1:0];
        frame_bad = (len_new > frame_lim);
        msg_sum   = {1'b0, total} + {1'b0, len_low};
        msg_bad   = (msg_sum > {1'b0, msg_lim});
        is_data   = (cur.current_opcode inside {OP_CONT, OP_TEXT, OP_BINARY});
        count_inc = cur.field_byte_count + 4'd1;
        mask_new  = (cur.phase == PH_HDR1) ? rx_byte[7] : cur.mask_present;
    end

    // Field completion for the extended length and the masking key.
    always_comb
    begin
        case (cur.phase)
            PH_LEN16:
            begin
                field_done = (count_inc == LEN16_BYTES);
            end
            PH_LEN64:
            begin
                field_done = (count_inc == LEN64_BYTES);
            end
            PH_MASK:
            begin
                field_done = (count_inc == KEY_BYTES);
            end
            default:
            begin
                field_done = 1'b0;
            end
        endcase
    end

    // Payload unmasking and the remaining count.
    always_comb
    begin
        case (cur.payload_index)
            2'd0:    key_byte = cur.mask_key[31:24];
            2'd1:    key_byte = cur.mask_key[23:16];
            2'd2:    key_byte = cur.mask_key[15:8];
            default: key_byte = cur.mask_key[7:0];
        endcase
        if (!cur.mask_present)
        begin
            key_byte = 8'd0;
        end
        pay_byte = rx_byte ^ key_byte;
        rem_dec  = remaining - {{(LEN_BITS-1){1'b0}}, 1'b1};
        pay_last = (rem_dec == '0);
    end

    // Checks and message bookkeeping once the header is complete.
    always_comb
    begin
        hd_valid = 1'b0;
        hd_kind  = KIND_DATA;
        hd_flast = 1'b0;
        hd_mlast = 1'b0;
        hd_halt  = 1'b0;
        hd_open  = cur.message_open;
        hd_total = total;
        case (cur.current_opcode)
            OP_CLOSE:
            begin
                hd_halt  = 1'b1;
                hd_valid = 1'b1;
                hd_kind  = KIND_CLOSE;
            end
            OP_CONT:
            begin
                if (!cur.message_open)
                begin
                    hd_halt  = 1'b1;
                    hd_valid = 1'b1;
                    hd_kind  = KIND_SEQ_ERR;
                end
                else if (msg_bad)
                begin
                    hd_halt  = 1'b1;
                    hd_valid = 1'b1;
                    hd_kind  = KIND_LEN_ERR;
                end
                else if (cur.fin_flag)
                begin
                    hd_open  = 1'b0;
                    hd_total = '0;
                end
                else
                begin
                    hd_total = msg_sum[LEN_BITS-1:0];
                end
            end
            OP_TEXT, OP_BINARY:
            begin
                if (cur.message_open)
                begin
                    hd_halt  = 1'b1;
                    hd_valid = 1'b1;
                    hd_kind  = KIND_SEQ_ERR;
                end
                else if (cur.fin_flag)
                begin
                    hd_total = '0;
                end
                else
                begin
                    hd_open  = 1'b1;
                    hd_total = len_low;
                end
            end
            OP_PING:
            begin
                if (len_zero)
                begin
                    hd_valid = 1'b1;
                    hd_kind  = KIND_EMPTY_PING;
                    hd_flast = 1'b1;
                end
            end
            OP_PONG:
            begin
                hd_valid = 1'b0;
            end
            default:
            begin
                hd_valid = 1'b1;
                hd_kind  = KIND_UNKNOWN;
            end
        endcase
        // An empty data frame still reports its end.
        if (is_data && len_zero && !hd_halt)
        begin
            hd_valid = 1'b1;
            hd_kind  = KIND_EMPTY_DATA;
            hd_flast = 1'b1;
            hd_mlast = cur.fin_flag;
        end
    end

    // Next parser state.
    always_comb
    begin
        nxt            = cur;
        remaining_next = remaining;
        total_next     = total;
        if (!cur.halted)
        begin
            case (cur.phase)
                PH_HDR0:
                begin
                    nxt.fin_flag       = rx_byte[7];
                    nxt.current_opcode = rx_byte[3:0];
                    nxt.phase          = PH_HDR1;
                end
                PH_HDR1, PH_LEN16, PH_LEN64, PH_MASK:
                begin
                    if (cur.phase == PH_HDR1)
                    begin
                        nxt.mask_present     = rx_byte[7];
                        nxt.field_byte_count = 4'd0;
                        nxt.length_shift     = 64'd0;
                    end
                    else
                    begin
                        nxt.field_byte_count = count_inc;
                        // Every extended length byte shifts into the length.
                        if (cur.phase != PH_MASK)
                        begin
                            nxt.length_shift = len_new;
                        end
                    end
                    if (cur.phase == PH_MASK)
                    begin
                        nxt.mask_key = {cur.mask_key[23:0], rx_byte};
                    end
                    if (cur.phase == PH_HDR1 && rx_byte[6:0] == LEN_CODE16)
                    begin
                        nxt.phase = PH_LEN16;
                    end
                    else if (cur.phase == PH_HDR1 && rx_byte[6:0] == LEN_CODE64)
                    begin
                        nxt.phase = PH_LEN64;
                    end
                    else if (cur.phase == PH_HDR1 || field_done)
                    begin
                        if (cur.phase != PH_MASK)
                        begin
                            nxt.length_shift = len_new;
                        end
                        // Length complete: frame limit first, then the key.
                        if (cur.phase != PH_MASK && frame_bad)
                        begin
                            nxt.halted = 1'b1;
                        end
                        else if (cur.phase != PH_MASK && mask_new)
                        begin
                            nxt.phase            = PH_MASK;
                            nxt.field_byte_count = 4'd0;
                            nxt.mask_key         = 32'd0;
                        end
                        else
                        begin
                            if (cur.phase != PH_MASK)
                            begin
                                nxt.mask_key = 32'd0;
                            end
                            nxt.halted       = hd_halt;
                            nxt.message_open = hd_open;
                            total_next       = hd_total;
                            if (!hd_halt)
                            begin
                                if (len_zero)
                                begin
                                    nxt.phase = PH_HDR0;
                                end
                                else
                                begin
                                    nxt.phase         = PH_PAYLOAD;
                                    remaining_next    = len_low;
                                    nxt.payload_index = 2'd0;
                                end
                            end
                        end
                    end
                end
                PH_PAYLOAD:
                begin
                    nxt.payload_index = cur.payload_index + 2'd1;
                    remaining_next    = rem_dec;
                    if (pay_last)
                    begin
                        nxt.phase = PH_HDR0;
                    end
                end
                default:
                begin
                    nxt.phase = PH_HDR0;
                end
            endcase
        end
    end

    // Result word for this byte.
    always_comb
    begin
        res_valid        = 1'b0;
        res.kind         = KIND_DATA;
        res.data         = 8'd0;
        res.opcode       = cur.current_opcode;
        res.frame_last   = 1'b0;
        res.message_last = 1'b0;
        if (!cur.halted)
        begin
            case (cur.phase)
                PH_HDR1, PH_LEN16, PH_LEN64, PH_MASK:
                begin
                    if ((cur.phase == PH_HDR1 && rx_byte[6:0] != LEN_CODE16 &&
                         rx_byte[6:0] != LEN_CODE64) || field_done)
                    begin
                        if (cur.phase != PH_MASK && frame_bad)
                        begin
                            res_valid = 1'b1;
                            res.kind  = KIND_LEN_ERR;
                        end
                        else if (cur.phase == PH_MASK || !mask_new)
                        begin
                            res_valid        = hd_valid;
                            res.kind         = hd_kind;
                            res.frame_last   = hd_flast;
                            res.message_last = hd_mlast;
                        end
                    end
                end
                PH_PAYLOAD:
                begin
                    res.data       = pay_byte;
                    res.frame_last = pay_last;
                    if (is_data)
                    begin
                        res_valid        = 1'b1;
                        res.kind         = KIND_DATA;
                        res.message_last = pay_last & cur.fin_flag;
                    end
                    else if (cur.current_opcode == OP_PING)
                    begin
                        res_valid = 1'b1;
                        res.kind  = KIND_PING;
                    end
                end
                default:
                begin
                    res_valid = 1'b0;
                end
            endcase
        end
    end

endmodule

/* src/websocket_frame_deframer.sv */
// A result word appears in the output register in the cycle after its byte is accepted.
// Throughput: one byte per cycle; the whole parse step sits between the state registers
// and the output register, and a new byte is taken whenever that register is empty or
// being read. After a close or an error the block drops every byte until reset.
// Reset (rst_n low, asynchronous) returns the parser to the first header byte and
// restores both length limits to 16777216.
// ============================================================================
// WebSocket frame deframer
// Parses received bytes into frames, unmasks payload bytes and streams them out
// with frame and message end marks; length limits are set over an APB port.
// ============================================================================
module websocket_frame_deframer
    import wsd_pkg::*;
#(
    parameter int LEN_BITS = 25
)
(
    input  logic        clk,
    input  logic        rst_n,
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Received bytes.
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  rx_byte,
    // Result words.
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  out_kind,
    output logic [7:0]  out_byte,
    output logic [3:0]  frame_opcode,
    output logic        frame_last,
    output logic        message_last
);

    localparam logic [63:0] LenMask = 64'hFFFF_FFFF_FFFF_FFFF >> (64 - LEN_BITS);

    logic [24:0]         max_frame_len_reg;
    logic [24:0]         max_message_len_reg;
    ctrl_t               ctrl_reg;
    ctrl_t               ctrl_next;
    logic [LEN_BITS-1:0] remaining_reg;
    logic [LEN_BITS-1:0] remaining_next;
    logic [LEN_BITS-1:0] total_reg;
    logic [LEN_BITS-1:0] total_next;
    logic                out_valid_reg;
    result_t             out_reg;
    logic                res_valid;
    result_t             res;
    logic [63:0]         frame_lim;
    logic [63:0]         msg_lim_wide;
    logic                cfg_write;
    logic                accept;

    // Register access.
    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite;
    assign prdata    = (paddr[2] == 1'(REG_MAX_MESSAGE)) ? {7'd0, max_message_len_reg}
                                                         : {7'd0, max_frame_len_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_frame_len_reg   <= LIMIT_RESET;
            max_message_len_reg <= LIMIT_RESET;
        end
        else if (cfg_write)
        begin
            if (paddr[2] == 1'(REG_MAX_FRAME))
            begin
                max_frame_len_reg <= pwdata[24:0];
            end
            else
            begin
                max_message_len_reg <= pwdata[24:0];
            end
        end
    end

    // Limits as seen at the parser's length width.
    assign frame_lim    = {39'd0, max_frame_len_reg} & LenMask;
    assign msg_lim_wide = {39'd0, max_message_len_reg} & LenMask;

    // A byte enters whenever the output register is free or being drained.
    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    wsd_step #(
        .LEN_BITS (LEN_BITS)
    ) u_step (
        .cur            (ctrl_reg),
        .remaining      (remaining_reg),
        .total          (total_reg),
        .rx_byte        (rx_byte),
        .frame_lim      (frame_lim),
        .msg_lim        (msg_lim_wide[LEN_BITS-1:0]),
        .nxt            (ctrl_next),
        .remaining_next (remaining_next),
        .total_next     (total_next),
        .res_valid      (res_valid),
        .res            (res)
    );

    // Parser state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg      <= '0;
            remaining_reg <= '0;
            total_reg     <= '0;
        end
        else if (accept)
        begin
            ctrl_reg      <= ctrl_next;
            remaining_reg <= remaining_next;
            total_reg     <= total_next;
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            out_valid_reg <= accept && res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && res_valid)
        begin
            out_reg <= res;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_kind     = out_reg.kind;
    assign out_byte     = out_reg.data;
    assign frame_opcode = out_reg.opcode;
    assign frame_last   = out_reg.frame_last;
    assign message_last = out_reg.message_last;

`ifndef ASSERT_OFF
    // A halted parser never produces another word.
    a_halted_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && ctrl_reg.halted) |=> !out_valid)
        else $error("result word produced while halted");

    // Halting always comes with a close or error word.
    a_halt_reported: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(ctrl_reg.halted) |-> (out_valid && (out_kind == KIND_CLOSE ||
            out_kind == KIND_LEN_ERR || out_kind == KIND_SEQ_ERR)))
        else $error("parser halted without a close or error word");

    // In the payload phase at least one payload byte is still due.
    a_payload_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl_reg.phase == PH_PAYLOAD && !ctrl_reg.halted) |-> (remaining_reg != '0))
        else $error("payload phase with nothing remaining");
`endif

endmodule
